### sv/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg - shared types and constants of the run-length sprite decoder
// Field widths, register indexes, queue entry and result formats.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

    localparam int ADDR_BITS      = 20;
    localparam int COORD_BITS     = 12;
    localparam int BYTE_BITS      = 8;
    localparam int LIMIT_BITS     = 2 * COORD_BITS;
    localparam int MAC_BITS       = (ADDR_BITS > LIMIT_BITS + 1) ? ADDR_BITS : LIMIT_BITS + 1;
    localparam int CMP_BITS       = (ADDR_BITS > LIMIT_BITS) ? ADDR_BITS : LIMIT_BITS;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_BITS = 2;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic [BYTE_BITS-1:0] LITERAL_MIN = BYTE_BITS'(3);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SURFACE_WIDTH  = 2'd0,
        REG_SURFACE_HEIGHT = 2'd1,
        REG_START_X        = 2'd2,
        REG_START_Y        = 2'd3
    } t_cfg_reg;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_COUNT   = 4'b0001,
        PH_VALUE   = 4'b0010,
        PH_CODE    = 4'b0100,
        PH_LITERAL = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_RUN     = 3'd1,
        OP_LIT     = 3'd2,
        OP_NEWLINE = 3'd3,
        OP_END     = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic                 first;   // first byte of an image
        logic [BYTE_BITS-1:0] len;
        logic [BYTE_BITS-1:0] val;
    } t_op;

    typedef struct packed {
        logic [COORD_BITS-1:0] width;
        logic [ADDR_BITS-1:0]  start_addr;
        logic [LIMIT_BITS-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [BYTE_BITS-1:0] len;
        logic [BYTE_BITS-1:0] val;
        logic                 eoi;
        logic                 oob;
    } t_result;

endpackage

`default_nettype wire

### sv/rsd_front.sv
// ----------------------------------------------------------------------------
// rsd_front - stream parser
// Tracks count/value/escape/literal phases and turns each byte into an op.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  wire  [rsd_pkg::BYTE_BITS-1:0]      i_byte,
    output rsd_pkg::t_op                       o_op
);

    rsd_pkg::t_phase                 r_phase, n_phase;
    logic [rsd_pkg::BYTE_BITS-1:0]   r_count, n_count;
    logic                            r_first, n_first;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        o_op.kind  = rsd_pkg::OP_NOP;
        o_op.first = r_first;
        o_op.len   = '0;
        o_op.val   = i_byte;
        case (r_phase)
            rsd_pkg::PH_COUNT: begin
                if (i_byte != '0) begin
                    n_count = i_byte;
                    n_phase = rsd_pkg::PH_VALUE;
                end else begin
                    n_phase = rsd_pkg::PH_CODE;
                end
            end
            rsd_pkg::PH_VALUE: begin
                o_op.kind = rsd_pkg::OP_RUN;
                o_op.len  = r_count;
                n_phase   = rsd_pkg::PH_COUNT;
            end
            rsd_pkg::PH_CODE: begin
                n_phase = rsd_pkg::PH_COUNT;
                if (i_byte >= rsd_pkg::LITERAL_MIN) begin
                    n_count = i_byte;
                    n_phase = rsd_pkg::PH_LITERAL;
                end else if (i_byte == '0) begin
                    o_op.kind = rsd_pkg::OP_NEWLINE;
                end else begin
                    o_op.kind = rsd_pkg::OP_END;
                end
            end
            rsd_pkg::PH_LITERAL: begin
                o_op.kind = rsd_pkg::OP_LIT;
                o_op.len  = rsd_pkg::BYTE_BITS'(1);
                n_count   = r_count - rsd_pkg::BYTE_BITS'(1);
                if (r_count == rsd_pkg::BYTE_BITS'(1)) begin
                    n_phase = rsd_pkg::PH_COUNT;
                end
            end
            default: begin
                n_phase = rsd_pkg::PH_COUNT;
            end
        endcase
        n_first = (o_op.kind == rsd_pkg::OP_END);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsd_pkg::PH_COUNT;
            r_count <= '0;
            r_first <= 1'b1;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_first <= n_first;
        end
    end

endmodule

`default_nettype wire

### sv/rsd_queue.sv
// ----------------------------------------------------------------------------
// rsd_queue - op queue between parser and address generator
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  rsd_pkg::t_op   i_op,
    input  wire            i_pop,
    output rsd_pkg::t_op   o_op,
    output logic           o_empty,
    output logic           o_full
);

    rsd_pkg::t_op                    r_mem [rsd_pkg::QUEUE_DEPTH];
    logic [rsd_pkg::QPTR_BITS-1:0]   r_wr_ptr, r_rd_ptr;
    logic [rsd_pkg::QCNT_BITS-1:0]   r_count;

    assign o_op    = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == rsd_pkg::QCNT_BITS'(rsd_pkg::QUEUE_DEPTH));

    function automatic logic [rsd_pkg::QPTR_BITS-1:0] f_next(
        input logic [rsd_pkg::QPTR_BITS-1:0] p
    );
        if (p == rsd_pkg::QPTR_BITS'(rsd_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + rsd_pkg::QPTR_BITS'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + rsd_pkg::QCNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - rsd_pkg::QCNT_BITS'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rsd_pkg::QCNT_BITS'(rsd_pkg::QUEUE_DEPTH))
        else $error("op queue count past depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("push into full op queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty op queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + rsd_pkg::QCNT_BITS'(1)))
        else $error("op queue count lost a push");

endmodule

`default_nettype wire

### sv/rsd_back.sv
// ----------------------------------------------------------------------------
// rsd_back - address generator and result register
// Holds write pointer and line base, executes ops, drives fill requests.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  rsd_pkg::t_cfg    i_cfg,
    input  rsd_pkg::t_op     i_op,
    input  wire              i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output rsd_pkg::t_result o_result
);

    logic [rsd_pkg::ADDR_BITS-1:0] r_ptr, n_ptr;
    logic [rsd_pkg::ADDR_BITS-1:0] r_lbase, n_lbase;
    logic [rsd_pkg::ADDR_BITS-1:0] base_ptr, base_lb;
    logic                          r_out_valid;
    rsd_pkg::t_result              r_result, n_result;
    logic                          has_result;
    logic                          slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // first op of an image reloads from the start address
    assign base_ptr = i_op.first ? i_cfg.start_addr : r_ptr;
    assign base_lb  = i_op.first ? i_cfg.start_addr : r_lbase;

    always_comb begin
        n_ptr        = base_ptr;
        n_lbase      = base_lb;
        has_result   = 1'b0;
        n_result.addr = base_ptr;
        n_result.len  = i_op.len;
        n_result.val  = i_op.val;
        n_result.eoi  = 1'b0;
        n_result.oob  = 1'b0;
        case (i_op.kind)
            rsd_pkg::OP_NOP: begin
            end
            rsd_pkg::OP_RUN, rsd_pkg::OP_LIT: begin
                has_result = (i_op.val != '0);
                n_ptr      = base_ptr + rsd_pkg::ADDR_BITS'(i_op.len);
            end
            rsd_pkg::OP_NEWLINE: begin
                n_lbase = base_lb + rsd_pkg::ADDR_BITS'(i_cfg.width);
                n_ptr   = n_lbase;
            end
            rsd_pkg::OP_END: begin
                has_result   = 1'b1;
                n_result.len = '0;
                n_result.val = '0;
                n_result.eoi = 1'b1;
                n_result.oob = rsd_pkg::CMP_BITS'(base_ptr) > rsd_pkg::CMP_BITS'(i_cfg.limit);
            end
            default: begin
            end
        endcase
        o_pop = !i_empty && (!has_result || slot_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_lbase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ptr   <= n_ptr;
                r_lbase <= n_lbase;
            end
            if (o_pop && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && has_result) begin
            r_result <= n_result;
        end
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("fill request dropped while stalled");

    a_end_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.eoi) |-> (r_result.len == '0 && r_result.val == '0))
        else $error("end request carries a fill");

    a_fill_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_result.eoi) |-> (r_result.val != '0 && !r_result.oob))
        else $error("fill request with transparent color or bound flag");

endmodule

`default_nettype wire

### sv/rle_sprite_decoder_core.sv
// ----------------------------------------------------------------------------
// rle_sprite_decoder_core - run-length sprite stream to fill requests
// Input channel: one encoded byte per request (i_in_valid / o_in_stall).
// Output channel: fill requests of address, length and color, plus an
// end-of-image request carrying the final pointer and the bound flag
// (o_out_valid / i_out_stall). Transparent runs and literals give none.
// Config channel: i_cfg_valid / o_cfg_ready, always ready; index 0 width,
// 1 height, 2 start_x, 3 start_y. Write only while the block is idle.
// Throughput: one byte per cycle while o_in_stall is low. Path: an
// accepted byte is written into the op queue and its request then into
// the output register that drives o_out_valid. The parser accepts bytes
// into a two-entry op queue; the address generator drains it into a
// single output register, so a stalled receiver fills the queue and
// then raises o_in_stall. Start address and bound product are
// registered again from the stored config registers.
// Reset: parser expects a count byte, pointer and line base are zero, the
// next byte starts a new image, width/height return to 640/480.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_sprite_decoder_core (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_in_valid,
    output logic                                   o_in_stall,
    input  wire  [rsd_pkg::BYTE_BITS-1:0]          i_src_byte,
    output logic                                   o_out_valid,
    input  wire                                    i_out_stall,
    output logic [rsd_pkg::ADDR_BITS-1:0]          o_write_address,
    output logic [rsd_pkg::BYTE_BITS-1:0]          o_write_length,
    output logic [rsd_pkg::BYTE_BITS-1:0]          o_pixel_value,
    output logic                                   o_end_of_image,
    output logic                                   o_out_of_bounds,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [rsd_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  wire  [rsd_pkg::COORD_BITS-1:0]         i_cfg_data
);

    logic [rsd_pkg::COORD_BITS-1:0] r_width, r_height, r_start_x, r_start_y;
    logic [rsd_pkg::ADDR_BITS-1:0]  r_start_addr;
    logic [rsd_pkg::LIMIT_BITS-1:0] r_limit;
    rsd_pkg::t_cfg                  cfg;
    rsd_pkg::t_op                   front_op, queue_op;
    rsd_pkg::t_result               result;
    logic                           in_accept, q_empty, q_full, q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= rsd_pkg::COORD_BITS'(rsd_pkg::WIDTH_RESET);
            r_height  <= rsd_pkg::COORD_BITS'(rsd_pkg::HEIGHT_RESET);
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (i_cfg_valid) begin
            case (rsd_pkg::t_cfg_reg'(i_cfg_index))
                rsd_pkg::REG_SURFACE_WIDTH:  r_width   <= i_cfg_data;
                rsd_pkg::REG_SURFACE_HEIGHT: r_height  <= i_cfg_data;
                rsd_pkg::REG_START_X:        r_start_x <= i_cfg_data;
                rsd_pkg::REG_START_Y:        r_start_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // derived config, one multiply per register
    always_ff @(posedge i_clk) begin
        r_start_addr <= rsd_pkg::ADDR_BITS'(
            rsd_pkg::MAC_BITS'(r_start_y) * rsd_pkg::MAC_BITS'(r_width)
            + rsd_pkg::MAC_BITS'(r_start_x));
        r_limit <= rsd_pkg::LIMIT_BITS'(r_width) * rsd_pkg::LIMIT_BITS'(r_height);
    end

    assign cfg.width      = r_width;
    assign cfg.start_addr = r_start_addr;
    assign cfg.limit      = r_limit;

    rsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_src_byte),
        .o_op     (front_op)
    );

    rsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_op    (front_op),
        .i_pop   (q_pop),
        .o_op    (queue_op),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_op        (queue_op),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_write_address = result.addr;
    assign o_write_length  = result.len;
    assign o_pixel_value   = result.val;
    assign o_end_of_image  = result.eoi;
    assign o_out_of_bounds = result.oob;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench of the run-length sprite decoder core
// Drives encoded byte streams, register settings and random idling. A
// scoreboard decodes each accepted byte on its own and checks every fill
// request, in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import rsd_pkg::*;

    // decodes the byte stream in step with the core, keeps the fills still owed
    class fill_scoreboard;
        logic [COORD_BITS-1:0] width, height, org_x, org_y;
        t_phase                phase;
        logic [BYTE_BITS-1:0]  run_left;
        logic [ADDR_BITS-1:0]  line_base, wptr;
        bit                    new_image;
        t_result               owed_fills[$];
        int                    errors;

        function void reset_model();
            width     = COORD_BITS'(WIDTH_RESET);
            height    = COORD_BITS'(HEIGHT_RESET);
            org_x     = '0;
            org_y     = '0;
            phase     = PH_COUNT;
            run_left  = '0;
            line_base = '0;
            wptr      = '0;
            new_image = 1'b1;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_reg idx, logic [COORD_BITS-1:0] v);
            case (idx)
                REG_SURFACE_WIDTH:  width  = v;
                REG_SURFACE_HEIGHT: height = v;
                REG_START_X:        org_x  = v;
                REG_START_Y:        org_y  = v;
                default: begin
                end
            endcase
        endfunction

        function void decode_byte(logic [BYTE_BITS-1:0] b);
            t_result     r;
            logic [31:0] limit;
            r = '0;
            // start position is latched at the first byte of each image
            if (new_image) begin
                line_base = ADDR_BITS'(32'(org_y) * 32'(width) + 32'(org_x));
                wptr      = line_base;
                new_image = 1'b0;
            end
            case (phase)
                PH_COUNT: begin
                    if (b != 0) begin
                        run_left = b;
                        phase    = PH_VALUE;
                    end else begin
                        phase = PH_CODE;
                    end
                end
                PH_VALUE: begin
                    if (b != 0) begin
                        r.addr = wptr;
                        r.len  = run_left;
                        r.val  = b;
                        owed_fills.push_back(r);
                    end
                    wptr     = wptr + ADDR_BITS'(run_left);
                    run_left = '0;
                    phase    = PH_COUNT;
                end
                PH_CODE: begin
                    if (b >= LITERAL_MIN) begin
                        run_left = b;
                        phase    = PH_LITERAL;
                    end else if (b == 0) begin
                        line_base = line_base + ADDR_BITS'(width);
                        wptr      = line_base;
                        phase     = PH_COUNT;
                    end else begin
                        limit  = 32'(width) * 32'(height);
                        r.addr = wptr;
                        r.eoi  = 1'b1;
                        r.oob  = 32'(wptr) > limit;
                        owed_fills.push_back(r);
                        phase     = PH_COUNT;
                        run_left  = '0;
                        new_image = 1'b1;
                    end
                end
                default: begin
                    if (b != 0) begin
                        r.addr = wptr;
                        r.len  = BYTE_BITS'(1);
                        r.val  = b;
                        owed_fills.push_back(r);
                    end
                    wptr     = wptr + ADDR_BITS'(1);
                    run_left = run_left - BYTE_BITS'(1);
                    if (run_left == 0) phase = PH_COUNT;
                end
            endcase
        endfunction

        function void check_fill(t_result got);
            t_result exp;
            if (owed_fills.size() == 0) begin
                $error("unexpected request: addr %0d len %0d val %0d",
                       got.addr, got.len, got.val);
                errors++;
                return;
            end
            exp = owed_fills.pop_front();
            if (got.addr != exp.addr) begin
                $error("write_address: expected %0d, got %0d", exp.addr, got.addr);
                errors++;
            end
            if (got.len != exp.len) begin
                $error("write_length: expected %0d, got %0d", exp.len, got.len);
                errors++;
            end
            if (got.val != exp.val) begin
                $error("pixel_value: expected %0d, got %0d", exp.val, got.val);
                errors++;
            end
            if (got.eoi != exp.eoi) begin
                $error("end_of_image: expected %0d, got %0d", exp.eoi, got.eoi);
                errors++;
            end
            if (got.oob != exp.oob) begin
                $error("out_of_bounds: expected %0d, got %0d", exp.oob, got.oob);
                errors++;
            end
        endfunction

        function int owed();
            return owed_fills.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic [BYTE_BITS-1:0]      i_src_byte = '0;
    logic                      i_out_stall = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [COORD_BITS-1:0]     i_cfg_data = '0;
    logic                      o_in_stall, o_out_valid, o_cfg_ready;
    logic [ADDR_BITS-1:0]      o_write_address;
    logic [BYTE_BITS-1:0]      o_write_length, o_pixel_value;
    logic                      o_end_of_image, o_out_of_bounds;

    fill_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_on = 1'b0;
    int  bytes_sent = 0;

    rle_sprite_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_src_byte      (i_src_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_address (o_write_address),
        .o_write_length  (o_write_length),
        .o_pixel_value   (o_pixel_value),
        .o_end_of_image  (o_end_of_image),
        .o_out_of_bounds (o_out_of_bounds),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #24000000;
        $display("tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.decode_byte(i_src_byte);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_fill(t_result'({o_write_address, o_write_length, o_pixel_value,
                                     o_end_of_image, o_out_of_bounds}));
    end

    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_src_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic hold_receiver(input int cycles);
        hold_on <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_on <= 1'b0;
    endtask

    // no request is left owed; a transparent op may still be in flight.
    // It first waits on the clock so the last accepted byte has been decoded.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [COORD_BITS-1:0] w, h, x, y);
        t_cfg_reg              regs[4] = '{REG_SURFACE_WIDTH, REG_SURFACE_HEIGHT,
                                           REG_START_X, REG_START_Y};
        logic [COORD_BITS-1:0] vals[4];
        vals = '{w, h, x, y};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(regs[i], vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one well-formed image, cut short if the phase runs out of bytes
    task automatic send_image(input int stop_at);
        int cmds, pick, n;
        cmds = $urandom_range(12, 1);
        for (int c = 0; c < cmds; c++) begin
            if (bytes_sent >= stop_at) return;
            pick = $urandom_range(99);
            if (pick < 55) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(255, 1) : $urandom_range(16, 1);
                send_byte(BYTE_BITS'(n));
                send_byte(($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
            end else if (pick < 70) begin
                send_byte(8'd0);
                send_byte(8'd0);
            end else begin
                n = ($urandom_range(30) == 0) ? $urandom_range(255, 3) : $urandom_range(8, 3);
                send_byte(8'd0);
                send_byte(BYTE_BITS'(n));
                repeat (n)
                    send_byte(($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
            end
        end
        if (bytes_sent >= stop_at) return;
        send_byte(8'd0);
        send_byte(8'($urandom_range(2, 1)));
    endtask

    task automatic send_stream(input int quota);
        int stop_at;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(12, 1)) send_byte(8'($urandom_range(255)));
            else
                send_image(stop_at);
        end
    endtask

    initial begin
        logic [COORD_BITS-1:0] w, h;
        sb = new;
        sb.reset_model();
        send_idle_pct = 23;
        recv_idle_pct <= 86;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: min and max runs, transparent run, literal with a
        // transparent byte, line advance, both stop codes, empty image
        send_byte(8'd1);   send_byte(8'd255);
        send_byte(8'd255); send_byte(8'd1);
        send_byte(8'd7);   send_byte(8'd0);
        send_byte(8'd0);   send_byte(8'd3);
        send_byte(8'd5);   send_byte(8'd0);   send_byte(8'd255);
        send_byte(8'd0);   send_byte(8'd0);
        send_byte(8'd4);   send_byte(8'd170);
        send_byte(8'd0);   send_byte(8'd1);
        send_byte(8'd0);   send_byte(8'd2);
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            send_idle_pct = (p < 3) ? 23 : (p < 6) ? 86 : 0;
            recv_idle_pct <= (p < 3) ? 86 : (p < 6) ? 23 : 0;
            w = COORD_BITS'($urandom_range(64, 1));
            h = COORD_BITS'($urandom_range(16, 1));
            case (p)
                0: configure(1, 1, 0, 0);
                1: configure(4095, 4095, 4094, 4094);   // start address wraps
                3: configure(4095, 1, 0, 4094);
                4: configure(640, 480, COORD_BITS'($urandom_range(4094)),
                             COORD_BITS'($urandom_range(4094)));
                default: configure(w, h, COORD_BITS'($urandom_range(w)),
                                   COORD_BITS'($urandom_range(h)));
            endcase
            // long receiver hold-off while bytes keep coming
            if (p == 2 || p == 7) fork hold_receiver(300); join_none
            send_stream(200);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
